@@ rtl/linear_adsr_envelope_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the linear ADSR envelope
// Concurrent check wrappers, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef LINEAR_ADSR_ENVELOPE_ASSERT_SVH
`define LINEAR_ADSR_ENVELOPE_ASSERT_SVH

`ifndef ASSERT_OFF
`define LAE_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");
`define LAE_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("%m: check failed");
`else
`define LAE_ASSERT(label, clk, rst_n, prop)
`define LAE_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif

`endif

@@ rtl/lae_pkg.sv @@
// ----------------------------------------------------------------------------
// lae_pkg
// Types, register map and constants shared by the envelope modules.
// ----------------------------------------------------------------------------
package lae_pkg;

  localparam int LEVEL_BITS        = 16;
  localparam int DEFAULT_TIME_BITS = 22;
  localparam int PHASE_BITS        = 3;
  localparam int ADDR_BITS         = 4;
  localparam int DATA_BITS         = 32;

  localparam int ATTACK_RESET  = 441;
  localparam int DECAY_RESET   = 4410;
  localparam int SUSTAIN_RESET = 45875;
  localparam int RELEASE_RESET = 4410;

  typedef enum logic [1:0] {
    REG_ATTACK  = 2'd0,
    REG_DECAY   = 2'd1,
    REG_SUSTAIN = 2'd2,
    REG_RELEASE = 2'd3
  } cfg_reg_e;

  typedef enum logic [PHASE_BITS-1:0] {
    PH_IDLE    = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } env_phase_e;

  typedef enum logic [2:0] {
    LVL_ZERO    = 3'd0,
    LVL_SUSTAIN = 3'd1,
    LVL_ATTACK  = 3'd2,
    LVL_DECAY   = 3'd3,
    LVL_RELEASE = 3'd4
  } lvl_sel_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_EVAL   = 3'd1,
    ST_MUL    = 3'd2,
    ST_DSTART = 3'd3,
    ST_DIV    = 3'd4,
    ST_OUT    = 3'd5
  } seq_state_e;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] gate_level;
    logic                  manual_hold;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] envelope_level;
    logic [PHASE_BITS-1:0] phase;
  } out_item_t;

  typedef struct packed {
    logic load_in;
    logic eval;
    logic mul;
    logic div_start;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_idle;
    logic out_free;
  } ctrl_sts_t;

endpackage

@@ rtl/lae_div.sv @@
// ----------------------------------------------------------------------------
// lae_div
// Restoring divider, one quotient bit per cycle, LEVEL_BITS steps.
// ----------------------------------------------------------------------------
`include "linear_adsr_envelope_assert.svh"

module lae_div import lae_pkg::*; #(
  parameter int TIME_BITS = DEFAULT_TIME_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [TIME_BITS+LEVEL_BITS-1:0] num_i,
  input  logic [TIME_BITS-1:0]            den_i,
  output logic                            idle_o,
  output logic [LEVEL_BITS-1:0]           quo_o
);

  localparam int CNT_W = $clog2(LEVEL_BITS + 1);

  logic [TIME_BITS-1:0]  rem_q;
  logic [LEVEL_BITS-1:0] quo_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  busy_q;
  logic [TIME_BITS:0]    trial;
  logic [TIME_BITS:0]    diff;
  logic                  fits;

  assign trial = {rem_q, quo_q[LEVEL_BITS-1]};
  assign diff  = trial - {1'b0, den_i};
  assign fits  = trial >= {1'b0, den_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(LEVEL_BITS);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i[TIME_BITS+LEVEL_BITS-1:LEVEL_BITS];
      quo_q <= num_i[LEVEL_BITS-1:0];
    end else if (busy_q) begin
      rem_q <= fits ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
      quo_q <= {quo_q[LEVEL_BITS-2:0], fits};
    end
  end

  assign idle_o = !busy_q;
  assign quo_o  = quo_q;

  `LAE_ASSERT(a_rem_below_den, clk_i, rst_ni, (busy_q && den_i != '0) |-> (rem_q < den_i))
  `LAE_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start_i, busy_q)

endmodule

@@ rtl/lae_ctrl.sv @@
// ----------------------------------------------------------------------------
// lae_ctrl
// Sequencer: accept, evaluate phase, multiply, divide, hand over result.
// ----------------------------------------------------------------------------
module lae_ctrl import lae_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  seq_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EVAL;
      end
      ST_EVAL:   state_d = ST_MUL;
      ST_MUL:    state_d = ST_DSTART;
      ST_DSTART: state_d = ST_DIV;
      ST_DIV: begin
        if (sts_i.div_idle) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    in_stall_o      = (state_q != ST_IDLE);
    cmd_o.load_in   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.eval      = (state_q == ST_EVAL);
    cmd_o.mul       = (state_q == ST_MUL);
    cmd_o.div_start = (state_q == ST_DSTART);
    cmd_o.out_load  = (state_q == ST_OUT) && sts_i.out_free;
  end

endmodule

@@ rtl/lae_dp.sv @@
// ----------------------------------------------------------------------------
// lae_dp
// Datapath: registers, phase and counter update, ramp level arithmetic.
// ----------------------------------------------------------------------------
`include "linear_adsr_envelope_assert.svh"

module lae_dp import lae_pkg::*; #(
  parameter int TIME_BITS = DEFAULT_TIME_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_data_o,
  input  ctrl_cmd_t            cmd_i,
  output ctrl_sts_t            sts_o
);

  localparam int PROD_W = TIME_BITS + LEVEL_BITS;

  logic [TIME_BITS-1:0]  attack_q, decay_q, release_q;
  logic [LEVEL_BITS-1:0] sustain_q;
  cfg_reg_e              reg_sel;
  logic                  cfg_wr;

  env_phase_e            phase_q, phase_d;
  logic [TIME_BITS:0]    tc_q, tc_e, tc_d;
  logic [TIME_BITS-1:0]  rc_q, rc_e, rc_d;
  logic [LEVEL_BITS-1:0] prev_q, gate_q;
  logic                  rise, fall;
  logic [TIME_BITS:0]    ad_sum, tc_off;

  logic [LEVEL_BITS:0]   mul_a_q, mul_a_d;
  logic [TIME_BITS-1:0]  mul_b_q, mul_b_d;
  logic [TIME_BITS-1:0]  den_q, den_d;
  lvl_sel_e              sel_q, sel_d;
  logic [PROD_W:0]       prod_full;
  logic [PROD_W-1:0]     prod_q;

  logic                  div_idle;
  logic [LEVEL_BITS-1:0] quo;
  logic [LEVEL_BITS-1:0] level;
  logic                  out_valid_q;
  out_item_t             out_data_q;

  assign reg_sel = cfg_reg_e'(paddr[ADDR_BITS-1:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= TIME_BITS'(ATTACK_RESET);
      decay_q   <= TIME_BITS'(DECAY_RESET);
      sustain_q <= LEVEL_BITS'(SUSTAIN_RESET);
      release_q <= TIME_BITS'(RELEASE_RESET);
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_ATTACK:  attack_q  <= pwdata[TIME_BITS-1:0];
        REG_DECAY:   decay_q   <= pwdata[TIME_BITS-1:0];
        REG_SUSTAIN: sustain_q <= pwdata[LEVEL_BITS-1:0];
        REG_RELEASE: release_q <= pwdata[TIME_BITS-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_ATTACK:  prdata = DATA_BITS'(attack_q);
      REG_DECAY:   prdata = DATA_BITS'(decay_q);
      REG_SUSTAIN: prdata = DATA_BITS'(sustain_q);
      REG_RELEASE: prdata = DATA_BITS'(release_q);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      gate_q <= in_data_i.manual_hold ? '1 : in_data_i.gate_level;
    end
  end

  assign rise   = gate_q > prev_q;
  assign fall   = gate_q < prev_q;
  assign ad_sum = {1'b0, attack_q} + {1'b0, decay_q};

  always_comb begin
    phase_d = phase_q;
    tc_e    = tc_q;
    rc_e    = rc_q;
    if (rise && phase_q == PH_IDLE) begin
      phase_d = PH_ATTACK;
      tc_e    = '0;
    end
    if (fall) begin
      phase_d = PH_RELEASE;
      rc_e    = '0;
    end
    if (phase_d == PH_ATTACK && tc_e >= {1'b0, attack_q}) phase_d = PH_DECAY;
    if (phase_d == PH_DECAY && tc_e >= ad_sum) phase_d = PH_SUSTAIN;
    if (phase_d == PH_RELEASE && rc_e >= release_q) phase_d = PH_IDLE;
  end

  assign tc_off = (tc_e > {1'b0, attack_q}) ? (tc_e - {1'b0, attack_q}) : '0;

  always_comb begin
    mul_a_d = '0;
    mul_b_d = '0;
    den_d   = '0;
    sel_d   = LVL_ZERO;
    tc_d    = tc_e;
    rc_d    = rc_e;
    unique case (phase_d)
      PH_ATTACK: begin
        mul_a_d = {1'b1, {LEVEL_BITS{1'b0}}};
        mul_b_d = tc_e[TIME_BITS-1:0];
        den_d   = attack_q;
        sel_d   = LVL_ATTACK;
      end
      PH_DECAY: begin
        mul_a_d = {1'b1, {LEVEL_BITS{1'b0}}} - {1'b0, sustain_q};
        mul_b_d = tc_off[TIME_BITS-1:0];
        den_d   = decay_q;
        sel_d   = (decay_q == '0) ? LVL_SUSTAIN : LVL_DECAY;
      end
      PH_SUSTAIN: sel_d = LVL_SUSTAIN;
      PH_RELEASE: begin
        mul_a_d = {1'b0, sustain_q};
        mul_b_d = rc_e;
        den_d   = release_q;
        sel_d   = LVL_RELEASE;
      end
      default:    sel_d = LVL_ZERO;
    endcase
    if ((phase_d == PH_ATTACK || phase_d == PH_DECAY) && tc_e != '1) begin
      tc_d = tc_e + 1'b1;
    end
    if (phase_d == PH_RELEASE && rc_e != '1) begin
      rc_d = rc_e + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tc_q    <= '0;
      rc_q    <= '0;
      prev_q  <= '0;
    end else if (cmd_i.eval) begin
      phase_q <= phase_d;
      tc_q    <= tc_d;
      rc_q    <= rc_d;
      prev_q  <= gate_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      mul_a_q <= mul_a_d;
      mul_b_q <= mul_b_d;
      den_q   <= den_d;
      sel_q   <= sel_d;
    end
    if (cmd_i.mul) begin
      prod_q <= prod_full[PROD_W-1:0];
    end
  end

  assign prod_full = mul_a_q * mul_b_q;

  lae_div #(
    .TIME_BITS(TIME_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (prod_q),
    .den_i   (den_q),
    .idle_o  (div_idle),
    .quo_o   (quo)
  );

  always_comb begin
    unique case (sel_q)
      LVL_ZERO:    level = '0;
      LVL_SUSTAIN: level = sustain_q;
      LVL_ATTACK:  level = quo;
      LVL_DECAY:   level = (quo == '0) ? '1 : (LEVEL_BITS'(0) - quo);
      LVL_RELEASE: level = sustain_q - quo;
      default:     level = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q.envelope_level <= level;
      out_data_q.phase          <= phase_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_data_q;
  assign sts_o.div_idle = div_idle;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  `LAE_ASSERT(a_idle_level_zero, clk_i, rst_ni, (out_valid_q && out_data_q.phase == PH_IDLE) |-> (out_data_q.envelope_level == '0))
  `LAE_ASSERT(a_sustain_level, clk_i, rst_ni, (out_valid_q && out_data_q.phase == PH_SUSTAIN) |-> (out_data_q.envelope_level == sustain_q))

endmodule

@@ rtl/linear_adsr_envelope.sv @@
// Sequence: an accepted gate beat is evaluated, multiplied, divided and loaded
//   into the output; a new beat is accepted only after the last is handed over.
//   The serial divider produces one quotient bit of the ramp level per cycle.
// Reset (asynchronous, active low): phase idle, counters and previous gate cleared,
//   registers back to their defaults; no clearing pass, ready at once.
// ----------------------------------------------------------------------------
// linear_adsr_envelope
// Linear ADSR envelope generator, one Q0.16 level per gate beat.
// ----------------------------------------------------------------------------
module linear_adsr_envelope import lae_pkg::*; #(
  parameter int TIME_BITS = DEFAULT_TIME_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_data_o
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  lae_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lae_dp #(
    .TIME_BITS(TIME_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
